// ===== src/tpss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tpss_pkg;

	localparam int SLOT_COUNT = 16;
	localparam int MAX_OUT    = 16;
	localparam int STEP_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W      = $clog2(MAX_OUT + 1);

	localparam logic [15:0] MAX_LEN_RST = 16'd65507;

	typedef enum logic [1:0] {
		REQ_TICK     = 2'd0,
		REQ_NOW      = 2'd1,
		REQ_DELAY    = 2'd2,
		REQ_PERIODIC = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		STAT_OK           = 3'd0,
		STAT_BAD_INTERVAL = 3'd1,
		STAT_NULL_BUF     = 3'd2,
		STAT_TOO_LONG     = 3'd3,
		STAT_FULL         = 3'd4
	} status_t;

	typedef enum logic {
		KIND_STATUS = 1'b0,
		KIND_SEND   = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TICK,
		S_INSERT,
		S_TICK_END,
		S_INSERT_END
	} state_t;

	typedef struct packed {
		logic [7:0]  countdown;
		logic [7:0]  period;
		logic [31:0] addr;
		logic [15:0] port;
		logic [15:0] handle;
		logic [15:0] len;
	} slot_data_t;

	typedef struct packed {
		logic       busy;
		slot_data_t data;
	} slot_t;

endpackage

`default_nettype wire

// ===== src/tpss_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tpss_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           shift_en,
	input  wire tpss_pkg::slot_t nxt,
	output tpss_pkg::slot_t     cur
);
	import tpss_pkg::*;

	logic       busy_q;
	slot_data_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (shift_en) begin
			busy_q <= nxt.busy;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			data_q <= nxt.data;
		end
	end

	assign cur.busy = busy_q;
	assign cur.data = data_q;

endmodule

`default_nettype wire

// ===== src/timed_periodic_send_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none

// send now and requests rejected at accept: result registered, valid in the cycle after the transaction
// tick and scheduled insert: the slot ring rotates once through all SLOT_COUNT cells, then an
// end state; a tick holds the ring while a send order waits on a stalled output
// ticks and inserts: no new request is taken until the ring pass and end state are done
// reset: all slots free, max_len_q back to 65507, output empty

module timed_periodic_send_scheduler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	// request channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [31:0] dest_addr,
	input  wire logic [15:0] dest_udp_port,
	input  wire logic [15:0] buffer_handle,
	input  wire logic        buffer_present,
	input  wire logic [15:0] payload_len,
	input  wire logic [7:0]  interval_ticks,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             result_kind,
	output logic [2:0]       status_code,
	output logic [31:0]      out_addr,
	output logic [15:0]      out_port,
	output logic [15:0]      out_handle,
	output logic [15:0]      out_len,
	output logic             last_result
);
	import tpss_pkg::*;

	// configuration register
	logic [15:0] max_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RST;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	// control state
	state_t            state_q, state_nxt;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  emit_cnt_q;
	logic              pend_valid_q;
	slot_data_t        pend_q;
	logic              placed_q;
	slot_data_t        new_q;

	// output register
	logic              out_valid_q;
	logic              out_kind_q;
	logic [2:0]        out_status_q;
	logic [31:0]       out_addr_q;
	logic [15:0]       out_port_q;
	logic [15:0]       out_handle_q;
	logic [15:0]       out_len_q;
	logic              out_last_q;

	// slot ring: cell 0 is the head, the processed head re-enters at the tail
	slot_t cell_cur [SLOT_COUNT];
	slot_t cell_nxt [SLOT_COUNT];
	slot_t head;
	slot_t head_nxt;
	logic  shift_en;

	genvar g;
	generate
		for (g = 0; g < SLOT_COUNT; g++) begin : g_ring
			if (g == SLOT_COUNT - 1) begin : g_tail
				assign cell_nxt[g] = head_nxt;
			end else begin : g_link
				assign cell_nxt[g] = cell_cur[g+1];
			end
			tpss_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (shift_en),
				.nxt      (cell_nxt[g]),
				.cur      (cell_cur[g])
			);
		end
	endgenerate

	assign head = cell_cur[0];

	// handshake helpers
	logic out_free;
	logic in_accept;
	logic last_step;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_accept = in_valid && !in_stall;
	assign last_step = (step_q == STEP_W'(SLOT_COUNT - 1));

	// request checks at accept time
	req_type_t req;
	logic      len_ok;
	logic      imm_result;
	logic      go_insert;
	kind_t     imm_kind;
	status_t   imm_status;

	assign req    = req_type_t'(req_type);
	assign len_ok = (payload_len <= max_len_q);

	always_comb begin
		imm_result = 1'b1;
		go_insert  = 1'b0;
		imm_kind   = KIND_STATUS;
		imm_status = STAT_OK;
		case (req)
			REQ_TICK: begin
				imm_result = 1'b0;
			end
			REQ_NOW: begin
				if (!buffer_present) begin
					imm_status = STAT_NULL_BUF;
				end else if (!len_ok) begin
					imm_status = STAT_TOO_LONG;
				end else begin
					imm_kind = KIND_SEND;
				end
			end
			REQ_DELAY, REQ_PERIODIC: begin
				if (interval_ticks == 8'd0) begin
					imm_status = STAT_BAD_INTERVAL;
				end else if (!buffer_present) begin
					imm_status = STAT_NULL_BUF;
				end else if (!len_ok) begin
					imm_status = STAT_TOO_LONG;
				end else begin
					imm_result = 1'b0;
					go_insert  = 1'b1;
				end
			end
			default: begin
				imm_result = 1'b0;
			end
		endcase
	end

	// head slot processing
	logic due;
	logic cnt_full;
	logic emit;
	logic scan_hold;

	assign due       = head.busy && (head.data.countdown <= 8'd1);
	assign cnt_full  = (emit_cnt_q >= CNT_W'(MAX_OUT));
	assign emit      = (state_q == S_TICK) && due && !cnt_full
		&& (head.data.len <= max_len_q);
	// a second order cannot advance while the first waits on a stalled output
	assign scan_hold = emit && pend_valid_q && !out_free;

	always_comb begin
		head_nxt = head;
		case (state_q)
			S_TICK: begin
				if (head.busy && !due) begin
					head_nxt.data.countdown = head.data.countdown - 8'd1;
				end else if (due && cnt_full) begin
					// out of result space, send on the next tick
					head_nxt.data.countdown = 8'd0;
				end else if (due) begin
					if (head.data.period != 8'd0) begin
						head_nxt.data.countdown = head.data.period;
					end else begin
						head_nxt.busy = 1'b0;
					end
				end
			end
			S_INSERT: begin
				if (!head.busy && !placed_q) begin
					head_nxt.busy = 1'b1;
					head_nxt.data = new_q;
				end
			end
			default: begin
				head_nxt = head;
			end
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					if (req == REQ_TICK) begin
						state_nxt = S_TICK;
					end else if (go_insert) begin
						state_nxt = S_INSERT;
					end
				end
			end
			S_TICK: begin
				if (!scan_hold && last_step) begin
					state_nxt = S_TICK_END;
				end
			end
			S_INSERT: begin
				if (last_step) begin
					state_nxt = S_INSERT_END;
				end
			end
			S_TICK_END: begin
				if (!pend_valid_q || out_free) begin
					state_nxt = S_IDLE;
				end
			end
			S_INSERT_END: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// state outputs
	logic       out_load;
	kind_t      o_kind;
	status_t    o_status;
	slot_data_t o_data;
	logic       o_last;

	always_comb begin
		in_stall = 1'b1;
		shift_en = 1'b0;
		out_load = 1'b0;
		o_kind   = KIND_STATUS;
		o_status = STAT_OK;
		o_data   = '0;
		o_last   = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = !out_free;
				if (in_accept && imm_result) begin
					out_load = 1'b1;
					o_kind   = imm_kind;
					o_status = imm_status;
					if (imm_kind == KIND_SEND) begin
						o_data.addr   = dest_addr;
						o_data.port   = dest_udp_port;
						o_data.handle = buffer_handle;
						o_data.len    = payload_len;
					end
				end
			end
			S_TICK: begin
				shift_en = !scan_hold;
				// a newer order proves the held one is not the last
				if (emit && pend_valid_q && !scan_hold) begin
					out_load = 1'b1;
					o_kind   = KIND_SEND;
					o_data   = pend_q;
					o_last   = 1'b0;
				end
			end
			S_INSERT: begin
				shift_en = 1'b1;
			end
			S_TICK_END: begin
				if (pend_valid_q && out_free) begin
					out_load = 1'b1;
					o_kind   = KIND_SEND;
					o_data   = pend_q;
				end
			end
			S_INSERT_END: begin
				if (out_free) begin
					out_load = 1'b1;
					o_status = placed_q ? STAT_OK : STAT_FULL;
				end
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			step_q       <= '0;
			emit_cnt_q   <= '0;
			pend_valid_q <= 1'b0;
			placed_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (in_accept) begin
				step_q       <= '0;
				emit_cnt_q   <= '0;
				pend_valid_q <= 1'b0;
				placed_q     <= 1'b0;
			end else begin
				if (shift_en) begin
					step_q <= step_q + 1'b1;
				end
				if (shift_en && emit) begin
					pend_valid_q <= 1'b1;
					emit_cnt_q   <= emit_cnt_q + 1'b1;
				end else if (state_q == S_TICK_END && out_load) begin
					pend_valid_q <= 1'b0;
				end
				if (state_q == S_INSERT && !head.busy) begin
					placed_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			new_q.countdown <= interval_ticks;
			new_q.period    <= (req == REQ_PERIODIC) ? interval_ticks : 8'd0;
			new_q.addr      <= dest_addr;
			new_q.port      <= dest_udp_port;
			new_q.handle    <= buffer_handle;
			new_q.len       <= payload_len;
		end
		if (shift_en && emit) begin
			pend_q <= head.data;
		end
		if (out_load) begin
			out_kind_q   <= o_kind;
			out_status_q <= o_status;
			out_addr_q   <= o_data.addr;
			out_port_q   <= o_data.port;
			out_handle_q <= o_data.handle;
			out_len_q    <= o_data.len;
			out_last_q   <= o_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = out_kind_q;
	assign status_code = out_status_q;
	assign out_addr    = out_addr_q;
	assign out_port    = out_port_q;
	assign out_handle  = out_handle_q;
	assign out_len     = out_len_q;
	assign last_result = out_last_q;

endmodule

`default_nettype wire

// ===== tb/sv/sched_result_checker.sv =====
`timescale 1ns / 1ps

module sched_result_checker
	import tpss_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [31:0] dest_addr,
	input  wire logic [15:0] dest_udp_port,
	input  wire logic [15:0] buffer_handle,
	input  wire logic        buffer_present,
	input  wire logic [15:0] payload_len,
	input  wire logic [7:0]  interval_ticks,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic        result_kind,
	input  wire logic [2:0]  status_code,
	input  wire logic [31:0] out_addr,
	input  wire logic [15:0] out_port,
	input  wire logic [15:0] out_handle,
	input  wire logic [15:0] out_len,
	input  wire logic        last_result,
	output int               error_count,
	output int               waiting_count,
	output int               orders_seen,
	output int               statuses_seen
);

	localparam int MAX_REPORTS = 40;

	typedef struct packed {
		kind_t       kind;
		status_t     status;
		logic [31:0] addr;
		logic [15:0] port;
		logic [15:0] handle;
		logic [15:0] len;
		logic        last;
	} sched_result_t;

	sched_result_t expected_q[$];

	// shadow copy of the slot table and the length limit
	logic [15:0] len_limit;
	logic        slot_busy   [SLOT_COUNT];
	logic [7:0]  slot_count  [SLOT_COUNT];
	logic [7:0]  slot_period [SLOT_COUNT];
	logic [31:0] slot_addr   [SLOT_COUNT];
	logic [15:0] slot_port   [SLOT_COUNT];
	logic [15:0] slot_handle [SLOT_COUNT];
	logic [15:0] slot_len    [SLOT_COUNT];

	function automatic sched_result_t status_result(status_t code);
		sched_result_t r;
		r = '0;
		r.kind = KIND_STATUS;
		r.status = code;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic sched_result_t send_result(logic [31:0] addr, logic [15:0] port,
			logic [15:0] handle, logic [15:0] len, logic last);
		sched_result_t r;
		r = '0;
		r.kind = KIND_SEND;
		r.status = STAT_OK;
		r.addr = addr;
		r.port = port;
		r.handle = handle;
		r.len = len;
		r.last = last;
		return r;
	endfunction

	// one tick: count down, emit due slots in slot order, reload or free
	function automatic void predict_tick();
		sched_result_t batch [MAX_OUT];
		int n;
		int i;
		n = 0;
		for (i = 0; i < SLOT_COUNT; i++) begin
			if (slot_busy[i]) begin
				if (slot_count[i] > 8'd1) begin
					slot_count[i] = slot_count[i] - 8'd1;
				end else if (n >= MAX_OUT) begin
					slot_count[i] = 8'd0;
				end else begin
					if (slot_len[i] <= len_limit) begin
						batch[n] = send_result(slot_addr[i], slot_port[i], slot_handle[i],
							slot_len[i], 1'b0);
						n++;
					end
					if (slot_period[i] != 8'd0)
						slot_count[i] = slot_period[i];
					else
						slot_busy[i] = 1'b0;
				end
			end
		end
		for (i = 0; i < n; i++) begin
			if (i == n - 1)
				batch[i].last = 1'b1;
			expected_q.push_back(batch[i]);
		end
	endfunction

	function automatic void predict_request(req_type_t rtype, logic [31:0] addr,
			logic [15:0] port, logic [15:0] handle, logic present, logic [15:0] len,
			logic [7:0] ival);
		int slot;
		int i;
		slot = -1;
		case (rtype)
		REQ_TICK: begin
			predict_tick();
		end
		REQ_NOW: begin
			if (!present)
				expected_q.push_back(status_result(STAT_NULL_BUF));
			else if (len > len_limit)
				expected_q.push_back(status_result(STAT_TOO_LONG));
			else
				expected_q.push_back(send_result(addr, port, handle, len, 1'b1));
		end
		default: begin
			for (i = SLOT_COUNT - 1; i >= 0; i--)
				if (!slot_busy[i])
					slot = i;
			if (ival == 8'd0) begin
				expected_q.push_back(status_result(STAT_BAD_INTERVAL));
			end else if (!present) begin
				expected_q.push_back(status_result(STAT_NULL_BUF));
			end else if (len > len_limit) begin
				expected_q.push_back(status_result(STAT_TOO_LONG));
			end else if (slot < 0) begin
				expected_q.push_back(status_result(STAT_FULL));
			end else begin
				slot_busy[slot] = 1'b1;
				slot_count[slot] = ival;
				slot_period[slot] = (rtype == REQ_PERIODIC) ? ival : 8'd0;
				slot_addr[slot] = addr;
				slot_port[slot] = port;
				slot_handle[slot] = handle;
				slot_len[slot] = len;
				expected_q.push_back(status_result(STAT_OK));
			end
		end
		endcase
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			error_count++;
			if (error_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	function automatic void check_result();
		sched_result_t want;
		if (expected_q.size() == 0) begin
			error_count++;
			if (error_count <= MAX_REPORTS)
				$display("%0t: unexpected result, expected none, actual kind %0d status %0d",
					$time, result_kind, status_code);
		end else begin
			want = expected_q.pop_front();
			if (result_kind == KIND_SEND)
				orders_seen++;
			else
				statuses_seen++;
			compare_field("result_kind", 32'(want.kind), 32'(result_kind));
			compare_field("status_code", 32'(want.status), 32'(status_code));
			compare_field("out_addr", want.addr, out_addr);
			compare_field("out_port", 32'(want.port), 32'(out_port));
			compare_field("out_handle", 32'(want.handle), 32'(out_handle));
			compare_field("out_len", 32'(want.len), 32'(out_len));
			compare_field("last_result", 32'(want.last), 32'(last_result));
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int i;
		if (!arst_n) begin
			expected_q.delete();
			len_limit = MAX_LEN_RST;
			for (i = 0; i < SLOT_COUNT; i++) begin
				slot_busy[i] = 1'b0;
				slot_count[i] = '0;
				slot_period[i] = '0;
				slot_addr[i] = '0;
				slot_port[i] = '0;
				slot_handle[i] = '0;
				slot_len[i] = '0;
			end
			error_count = 0;
			waiting_count = 0;
			orders_seen = 0;
			statuses_seen = 0;
		end else begin
			// a result can never come from a transaction on the same edge
			if (out_valid && !out_stall)
				check_result();
			if (cfg_wr_en)
				len_limit = cfg_wr_data;
			if (in_valid && !in_stall)
				predict_request(req_type_t'(req_type), dest_addr, dest_udp_port,
					buffer_handle, buffer_present, payload_len, interval_ticks);
			waiting_count = expected_q.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import tpss_pkg::*;

	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 5;
	// watchdog bound on the length of the whole run
	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_CYCLES   = 400;
	// covers a full ring pass and end state, with margin, for ticks that give no result
	localparam int DRAIN_CYCLES  = 2 * SLOT_COUNT + 8;
	localparam int IDLE_PERCENT  = 6;
	localparam int PERIODIC_CAP  = 7;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  req_type;
	logic [31:0] dest_addr;
	logic [15:0] dest_udp_port;
	logic [15:0] buffer_handle;
	logic        buffer_present;
	logic [15:0] payload_len;
	logic [7:0]  interval_ticks;
	logic        out_valid;
	logic        out_stall;
	logic        result_kind;
	logic [2:0]  status_code;
	logic [31:0] out_addr;
	logic [15:0] out_port;
	logic [15:0] out_handle;
	logic [15:0] out_len;
	logic        last_result;

	int error_count;
	int waiting_count;
	int orders_seen;
	int statuses_seen;

	// stimulus controls and run counters; no_idle and hold_request are shared with the receiver process
	logic no_idle;
	logic hold_request;
	int   cur_limit;
	int   periodic_live;
	int   items_sent;
	int   limits_used;
	int   cycle_count;

	timed_periodic_send_scheduler u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.dest_addr      (dest_addr),
		.dest_udp_port  (dest_udp_port),
		.buffer_handle  (buffer_handle),
		.buffer_present (buffer_present),
		.payload_len    (payload_len),
		.interval_ticks (interval_ticks),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_kind    (result_kind),
		.status_code    (status_code),
		.out_addr       (out_addr),
		.out_port       (out_port),
		.out_handle     (out_handle),
		.out_len        (out_len),
		.last_result    (last_result)
	);

	// watches both channels, predicts every transaction and compares results
	sched_result_checker u_checker (.*);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// watchdog: a hang anywhere ends the run as a failure
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_count,
				waiting_count);
			$display("[timed_periodic_send_scheduler] ERROR");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold-off so the block backs up
	initial begin
		logic hold_done;
		hold_done = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_stall = !no_idle && ($urandom_range(0, 99) < IDLE_PERCENT);
		end
	end

	// drive one request at the falling edge and hold it until the transaction happens
	task automatic send_request(req_type_t rtype, logic [31:0] addr, logic [15:0] port,
			logic [15:0] handle, logic present, logic [15:0] len, logic [7:0] ival);
		@(negedge clk);
		while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		req_type = rtype;
		dest_addr = addr;
		dest_udp_port = port;
		buffer_handle = handle;
		buffer_present = present;
		payload_len = len;
		interval_ticks = ival;
		in_valid = 1'b1;
		// stall is read before the edge updates it
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	// a tick carries junk in the unused fields
	task automatic tick_once();
		send_request(REQ_TICK, $urandom, 16'($urandom), 16'($urandom),
			1'($urandom_range(0, 1)), 16'($urandom), 8'($urandom));
	endtask

	// sender pauses until every expected result is back and the ring has settled
	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (waiting_count != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_limit(int value);
		wait_idle();
		cfg_wr_en = 1'b1;
		cfg_wr_data = value[15:0];
		@(negedge clk);
		cfg_wr_en = 1'b0;
		cur_limit = value;
		limits_used++;
	endtask

	// mostly well-formed traffic with random content, some malformed requests
	task automatic random_request();
		int pick;
		req_type_t rtype;
		logic present;
		logic [15:0] len;
		logic [7:0] ival;
		pick = $urandom_range(0, 99);
		present = 1'b1;
		len = 16'($urandom_range(0, cur_limit));
		// short intervals keep slots turning over, a few long ones park in the table
		ival = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255))
			: 8'($urandom_range(1, 4));
		if (pick < 35) begin
			rtype = REQ_TICK;
		end else if (pick < 50) begin
			rtype = REQ_NOW;
		end else if (pick < 84) begin
			// periodic slots never free up, so cap them to keep inserts succeeding
			if (pick >= 72 && periodic_live < PERIODIC_CAP) begin
				rtype = REQ_PERIODIC;
				periodic_live++;
			end else begin
				rtype = REQ_DELAY;
			end
		end else begin
			rtype = req_type_t'($urandom_range(1, 3));
			present = 1'($urandom_range(0, 1));
			len = 16'($urandom);
			ival = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
		end
		send_request(rtype, $urandom, 16'($urandom), 16'($urandom), present, len, ival);
	endtask

	initial begin
		// every input known from time zero
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		req_type = '0;
		dest_addr = '0;
		dest_udp_port = '0;
		buffer_handle = '0;
		buffer_present = 1'b0;
		payload_len = '0;
		interval_ticks = '0;
		no_idle = 1'b0;
		hold_request = 1'b0;
		cur_limit = int'(MAX_LEN_RST);
		periodic_live = 2;
		items_sent = 0;
		limits_used = 1;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// send now: smallest and largest fields, length exactly at the reset limit and one past it
		send_request(REQ_NOW, 32'h0, 16'h0, 16'h0, 1'b1, 16'd0, 8'd0);
		send_request(REQ_NOW, '1, '1, '1, 1'b1, MAX_LEN_RST, '1);
		send_request(REQ_NOW, 32'h1234_5678, 16'h0050, 16'h0001, 1'b1, MAX_LEN_RST + 16'd1,
			8'd3);
		// null buffer wins over a bad length
		send_request(REQ_NOW, 32'hc0a8_0001, 16'd53, 16'd7, 1'b0, '1, 8'd1);
		// zero interval wins over null buffer and bad length
		send_request(REQ_DELAY, 32'h0a00_0001, 16'd1, 16'd2, 1'b0, 16'd10, 8'd0);
		send_request(REQ_PERIODIC, 32'h0a00_0002, 16'd3, 16'd4, 1'b1, '1, 8'd0);
		send_request(REQ_DELAY, 32'h0a00_0003, 16'd5, 16'd6, 1'b0, 16'd10, 8'd5);
		send_request(REQ_PERIODIC, 32'h0a00_0004, 16'd7, 16'd8, 1'b1,
			MAX_LEN_RST + 16'd1, 8'd2);
		// accepted: one-shot due next tick, period two, and one that parks for 255 ticks
		send_request(REQ_DELAY, 32'hdead_beef, 16'hbeef, 16'h00aa, 1'b1, 16'd100, 8'd1);
		send_request(REQ_PERIODIC, 32'h8000_0001, 16'h8001, 16'h5555, 1'b1, 16'd100, 8'd2);
		send_request(REQ_DELAY, '1, '1, '1, 1'b1, MAX_LEN_RST, 8'd255);
		// one-shot fires, then the periodic slot every second tick, quiet ticks between
		repeat (4) tick_once();

		// limit dropped below a stored length: the due slot reloads but sends nothing
		set_limit(0);
		repeat (2) tick_once();
		send_request(REQ_NOW, 32'h0102_0304, 16'd9, 16'd10, 1'b1, 16'd0, 8'd0);
		send_request(REQ_NOW, 32'h0102_0305, 16'd9, 16'd11, 1'b1, 16'd1, 8'd0);

		// largest limit: full-length sends pass and two slots fall due on one tick
		set_limit(65535);
		send_request(REQ_NOW, 32'h7fff_ffff, 16'h7fff, 16'h7fff, 1'b1, '1, 8'd0);
		send_request(REQ_PERIODIC, 32'h4000_0000, 16'h4000, 16'h4000, 1'b1, '1, 8'd1);
		repeat (2) tick_once();

		// fill the table past its size, then let the short delays drain
		repeat (SLOT_COUNT + 1)
			send_request(REQ_DELAY, $urandom, 16'($urandom), 16'($urandom), 1'b1,
				16'($urandom_range(0, cur_limit)), 8'($urandom_range(1, 3)));
		repeat (4) tick_once();

		// random traffic under the largest limit
		wait_idle();
		repeat (30) random_request();

		// mid-range limit; the result side holds off while requests keep coming
		set_limit($urandom_range(1000, 60000));
		hold_request = 1'b1;
		repeat (40) random_request();

		// back to the reset limit, first a stretch with no idling on either side
		set_limit(int'(MAX_LEN_RST));
		no_idle = 1'b1;
		repeat (25) random_request();
		no_idle = 1'b0;
		repeat (15) random_request();

		// let every result come out, then allow for a last quiet tick
		wait_idle();

		$display("covered %0d requests, %0d send orders, %0d status results", items_sent,
			orders_seen, statuses_seen);
		$display("limits: %0d settings incl. 0 and 65535, table overflow, %0d-cycle hold-off",
			limits_used, HOLD_CYCLES);
		if (error_count == 0 && waiting_count == 0) begin
			$display("[timed_periodic_send_scheduler] OK");
		end else begin
			$display("%0d mismatches, %0d results never arrived", error_count, waiting_count);
			$display("[timed_periodic_send_scheduler] ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/tpss_pkg.sv
src/tpss_cell.sv
src/timed_periodic_send_scheduler.sv
tb/sv/sched_result_checker.sv
tb/sv/tb.sv
